// ===== sv/serial_command_frame_parser_macros.svh =====
// Assertion macros shared by the frame parser modules.
`ifndef SERIAL_COMMAND_FRAME_PARSER_MACROS_SVH
`define SERIAL_COMMAND_FRAME_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define SCFP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle gives a consequence in the next.
`define SCFP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SCFP_ASSERT(lbl, prop, msg)
`define SCFP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/scfp_pkg.sv =====
// Shared types and constants of the serial command frame parser.
`default_nettype none

package scfp_pkg;

	localparam int CAPTURE_BYTES = 10;
	localparam int CAP_IDX_W     = $clog2(CAPTURE_BYTES);
	localparam int NUM_FIELDS    = 5;
	localparam int FIELD_IDX_W   = 3;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QUEUE_PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] HEADER_BYTE = 8'hAA;
	localparam logic [7:0] MAX_LEN     = 8'd250;
	localparam logic [7:0] CODE_WORDS  = 8'h80;
	localparam logic [7:0] CODE_MIXED  = 8'h82;
	localparam logic [7:0] CODE_PAIR   = 8'h90;

	localparam logic [7:0] CFG_OWN_ADDR   = 8'd0;
	localparam logic [7:0] CFG_BCAST_ADDR = 8'd1;

	typedef enum logic [1:0] {
		ST_FIELD   = 2'd0,
		ST_NOFIELD = 2'd1,
		ST_CKFAIL  = 2'd2
	} status_t;

	// One finished frame, ready to be expanded into result beats.
	typedef struct packed {
		status_t                          status;
		logic [7:0]                       code;
		logic [FIELD_IDX_W-1:0]           count;
		logic [NUM_FIELDS-1:0][15:0]      value;
	} job_t;

endpackage

`default_nettype wire

// ===== sv/scfp_front.sv =====
// Frame parser front: tracks frame bytes, checksums and payload; one job per accepted frame.
`default_nettype none

module scfp_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [7:0]   rx_byte,
	input  wire logic         cfg_valid,
	input  wire logic [7:0]   cfg_index,
	input  wire logic [7:0]   cfg_data,
	input  wire logic         push_ready,
	output logic              push_valid,
	output scfp_pkg::job_t    push_job
);
	import scfp_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_DEST  = 3'd1,
		PH_CODE  = 3'd2,
		PH_LEN   = 3'd3,
		PH_DATA  = 3'd4,
		PH_SUM   = 3'd5,
		PH_ADDON = 3'd6
	} phase_t;

	phase_t     phase_q;
	logic [7:0] left_q;
	logic [7:0] pos_q;
	logic [7:0] sum_q;
	logic [7:0] sos_q;
	logic [7:0] code_q;
	logic [7:0] sum_byte_q;
	logic [7:0] own_q;
	logic [7:0] bcast_q;
	logic [7:0] cap_q [CAPTURE_BYTES];

	logic       accept;
	logic [7:0] sum_nx;
	logic [7:0] sos_nx;
	logic       ck_ok;

	// Only the add-on byte needs room in the job queue.
	assign in_ready   = (phase_q != PH_ADDON) || push_ready;
	assign accept     = in_valid && in_ready;
	assign push_valid = accept && (phase_q == PH_ADDON);

	assign sum_nx = sum_q + rx_byte;
	assign sos_nx = sos_q + sum_nx;
	assign ck_ok  = (sum_q == sum_byte_q) && (sos_q == rx_byte);

	always_comb begin
		push_job        = '0;
		push_job.code   = code_q;
		push_job.count  = FIELD_IDX_W'(1);
		push_job.status = ST_NOFIELD;
		if (!ck_ok) begin
			push_job.status = ST_CKFAIL;
		end else begin
			unique case (code_q)
				CODE_WORDS: begin
					push_job.status = ST_FIELD;
					push_job.count  = FIELD_IDX_W'(NUM_FIELDS);
					for (int i = 0; i < NUM_FIELDS; i++) begin
						push_job.value[i] = {cap_q[2*i], cap_q[2*i+1]};
					end
				end
				CODE_MIXED: begin
					push_job.status = ST_FIELD;
					push_job.count  = FIELD_IDX_W'(NUM_FIELDS);
					for (int i = 0; i < NUM_FIELDS - 1; i++) begin
						push_job.value[i] = {8'h00, cap_q[i]};
					end
					push_job.value[NUM_FIELDS-1] = {cap_q[4], cap_q[5]};
				end
				CODE_PAIR: begin
					push_job.status   = ST_FIELD;
					push_job.count    = FIELD_IDX_W'(2);
					push_job.value[0] = {8'h00, cap_q[0]};
					push_job.value[1] = {8'h00, cap_q[1]};
				end
				default: begin
					push_job.status = ST_NOFIELD;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			left_q     <= '0;
			pos_q      <= '0;
			sum_q      <= '0;
			sos_q      <= '0;
			code_q     <= '0;
			sum_byte_q <= '0;
			own_q      <= 8'h00;
			bcast_q    <= 8'hFF;
			for (int i = 0; i < CAPTURE_BYTES; i++) begin
				cap_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_OWN_ADDR:   own_q   <= cfg_data;
					CFG_BCAST_ADDR: bcast_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				unique case (phase_q)
					PH_IDLE: begin
						if (rx_byte == HEADER_BYTE) begin
							sum_q   <= rx_byte;
							sos_q   <= rx_byte;
							pos_q   <= '0;
							left_q  <= '0;
							phase_q <= PH_DEST;
							for (int i = 0; i < CAPTURE_BYTES; i++) begin
								cap_q[i] <= '0;
							end
						end
					end
					PH_DEST: begin
						if (rx_byte == own_q || rx_byte == bcast_q) begin
							sum_q   <= sum_nx;
							sos_q   <= sos_nx;
							phase_q <= PH_CODE;
						end else begin
							phase_q <= PH_IDLE;
						end
					end
					PH_CODE: begin
						code_q  <= rx_byte;
						sum_q   <= sum_nx;
						sos_q   <= sos_nx;
						phase_q <= PH_LEN;
					end
					PH_LEN: begin
						if (rx_byte < MAX_LEN) begin
							sum_q   <= sum_nx;
							sos_q   <= sos_nx;
							left_q  <= rx_byte;
							pos_q   <= '0;
							phase_q <= (rx_byte == 8'd0) ? PH_SUM : PH_DATA;
						end else begin
							phase_q <= PH_IDLE;
						end
					end
					PH_DATA: begin
						sum_q <= sum_nx;
						sos_q <= sos_nx;
						// bytes past the capture window only feed the checksums
						if (pos_q < 8'(CAPTURE_BYTES)) begin
							cap_q[pos_q[CAP_IDX_W-1:0]] <= rx_byte;
						end
						pos_q  <= pos_q + 8'd1;
						left_q <= left_q - 8'd1;
						if (left_q == 8'd1) begin
							phase_q <= PH_SUM;
						end
					end
					PH_SUM: begin
						sum_byte_q <= rx_byte;
						phase_q    <= PH_ADDON;
					end
					PH_ADDON: begin
						phase_q <= PH_IDLE;
					end
					default: begin
						phase_q <= PH_IDLE;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/scfp_queue.sv =====
// Short job queue between the parser front and the result back end.
`default_nettype none

`include "serial_command_frame_parser_macros.svh"

module scfp_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire scfp_pkg::job_t  push_job,
	output logic                 pop_valid,
	input  wire logic            pop_ready,
	output scfp_pkg::job_t       pop_job
);
	import scfp_pkg::*;

	job_t                   mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   do_push;
	logic                   do_pop;

	assign push_ready = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`SCFP_ASSERT(a_no_push_when_full, push_valid |-> push_ready, "job pushed into a full queue")
	`SCFP_ASSERT_NEXT(a_push_visible, do_push, pop_valid, "pushed job not visible at the head")

endmodule

`default_nettype wire

// ===== sv/scfp_back.sv =====
// Result back end: expands each queued job into result beats through an output register.
`default_nettype none

`include "serial_command_frame_parser_macros.svh"

module scfp_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            pop_valid,
	output logic                 pop_ready,
	input  wire scfp_pkg::job_t  pop_job,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [1:0]           status,
	output logic [7:0]           frame_code,
	output logic [2:0]           field_index,
	output logic [15:0]          field_value,
	output logic                 last
);
	import scfp_pkg::*;

	logic [FIELD_IDX_W-1:0] k_q;
	logic                   valid_q;
	status_t                status_q;
	logic [7:0]             code_q;
	logic [FIELD_IDX_W-1:0] index_q;
	logic [15:0]            value_q;
	logic                   last_q;
	logic                   load;
	logic                   final_beat;

	assign load       = pop_valid && (!valid_q || out_ready);
	assign final_beat = (k_q == pop_job.count - 1'b1);
	// Drop the job once its final beat moves into the output register.
	assign pop_ready  = load && final_beat;

	assign out_valid   = valid_q;
	assign status      = status_q;
	assign frame_code  = code_q;
	assign field_index = index_q;
	assign field_value = value_q;
	assign last        = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= pop_job.status;
			code_q   <= pop_job.code;
			index_q  <= k_q;
			value_q  <= pop_job.value[k_q];
			last_q   <= final_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			k_q     <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				k_q     <= final_beat ? '0 : k_q + 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	`SCFP_ASSERT(a_k_in_range, pop_valid |-> (k_q < pop_job.count), "field counter past job end")
	`SCFP_ASSERT(a_single_beat_last, (valid_q && status_q != ST_FIELD) |-> last_q,
		"fieldless result not marked last")

endmodule

`default_nettype wire

// ===== sv/serial_command_frame_parser.sv =====
// Top level of the serial command frame parser.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_ready    rx_byte
//   result    out        out_valid / out_ready  status, frame_code, field_index,
//                                               field_value, last
//   config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle while in_ready is high; the parser front updates its state in that cycle.
// The add-on byte of a frame waits only while the two-entry job queue is full.
// The back end sends one result per cycle from its output register while out_ready is high,
// one to five per frame; a frame's results follow its add-on byte through the job queue.
// Reset is asynchronous; it leaves the parser idle with control registers at their defaults.
// Configuration writes are always taken.
`default_nettype none

module serial_command_frame_parser (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [7:0]   rx_byte,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [1:0]        status,
	output logic [7:0]        frame_code,
	output logic [2:0]        field_index,
	output logic [15:0]       field_value,
	output logic              last,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [7:0]   cfg_index,
	input  wire logic [7:0]   cfg_data
);
	import scfp_pkg::*;

	logic push_valid;
	logic push_ready;
	job_t push_job;
	logic pop_valid;
	logic pop_ready;
	job_t pop_job;

	assign cfg_ready = 1'b1;

	scfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_job   (push_job)
	);

	scfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	scfp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_job     (pop_job),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.frame_code  (frame_code),
		.field_index (field_index),
		.field_value (field_value),
		.last        (last)
	);

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the serial command frame parser: directed frames, then random traffic.
module tb;
	import scfp_pkg::*;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 20;
	localparam int PRINT_LIMIT   = 40;
	localparam int DIRECTED_ROWS = 14;
	localparam int RANDOM_BUDGET = 25;

	localparam logic [7:0] CFG_SPARE = CFG_BCAST_ADDR + 8'd1;
	localparam logic [7:0] CFG_TOP   = 8'hFF;

	typedef enum logic [2:0] {
		PH_IDLE, PH_DEST, PH_CODE, PH_LEN, PH_DATA, PH_SUM, PH_ADDON
	} phase_t;

	typedef enum {FILL_CONST, FILL_RAMP, FILL_RANDOM} fill_t;
	typedef enum {CK_GOOD, CK_BAD_SUM, CK_BAD_ADDON} ck_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  code;
		logic [2:0]  index;
		logic [15:0] value;
		logic        last;
	} frame_result_t;

	typedef struct {
		logic [7:0]    dest;
		logic [7:0]    code;
		logic [7:0]    len;
		fill_t         fill;
		logic [7:0]    seed;
		ck_t           ck;
		bit            typed;
		frame_result_t want;
	} frame_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [7:0]  frame_code;
	logic [2:0]  field_index;
	logic [15:0] field_value;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = 8'h00;
	logic [7:0]  cfg_data = 8'h00;

	bit idle_on = 1'b1;
	int errors = 0;
	int bytes_sent = 0;

	// Parser mirror
	logic [7:0] own_addr = 8'h00;
	logic [7:0] bcast_addr = 8'hFF;
	phase_t     fp_phase = PH_IDLE;
	logic [7:0] fp_left = '0;
	logic [7:0] fp_pos = '0;
	logic [7:0] fp_sum = '0;
	logic [7:0] fp_sos = '0;
	logic [7:0] fp_code = '0;
	logic [7:0] fp_sum_byte = '0;
	logic [7:0] fp_capture[CAPTURE_BYTES];

	frame_result_t new_results[$];
	frame_result_t pending_results[$];
	frame_row_t    directed_rows[DIRECTED_ROWS];

	serial_command_frame_parser i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.frame_code  (frame_code),
		.field_index (field_index),
		.field_value (field_value),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		foreach (fp_capture[j]) fp_capture[j] = 8'h00;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
	endtask

	function automatic logic [7:0] captured(input int i);
		return (i < CAPTURE_BYTES) ? fp_capture[i] : 8'h00;
	endfunction

	function automatic void fold_byte(input logic [7:0] b);
		fp_sum = fp_sum + b;
		fp_sos = fp_sos + fp_sum;
	endfunction

	function automatic void emit_result(input status_t s, input logic [2:0] idx,
			input logic [15:0] v, input logic l);
		new_results.push_back('{s, fp_code, idx, v, l});
	endfunction

	function automatic void parse_byte(input logic [7:0] b);
		int i;
		case (fp_phase)
			PH_IDLE: begin
				if (b == HEADER_BYTE) begin
					fp_sum = '0;
					fp_sos = '0;
					fp_pos = '0;
					fp_left = '0;
					for (i = 0; i < CAPTURE_BYTES; i++) fp_capture[i] = 8'h00;
					fold_byte(b);
					fp_phase = PH_DEST;
				end
			end
			PH_DEST: begin
				if (b == own_addr || b == bcast_addr) begin
					fold_byte(b);
					fp_phase = PH_CODE;
				end else begin
					fp_phase = PH_IDLE;
				end
			end
			PH_CODE: begin
				fp_code = b;
				fold_byte(b);
				fp_phase = PH_LEN;
			end
			PH_LEN: begin
				if (b < MAX_LEN) begin
					fold_byte(b);
					fp_left = b;
					fp_pos = '0;
					fp_phase = (b == 8'd0) ? PH_SUM : PH_DATA;
				end else begin
					fp_phase = PH_IDLE;
				end
			end
			PH_DATA: begin
				fold_byte(b);
				if (fp_pos < CAPTURE_BYTES) fp_capture[fp_pos] = b;
				fp_pos = fp_pos + 8'd1;
				fp_left = fp_left - 8'd1;
				if (fp_left == 8'd0) fp_phase = PH_SUM;
			end
			PH_SUM: begin
				fp_sum_byte = b;
				fp_phase = PH_ADDON;
			end
			PH_ADDON: begin
				fp_phase = PH_IDLE;
				if (fp_sum != fp_sum_byte || fp_sos != b) begin
					emit_result(ST_CKFAIL, 3'd0, 16'h0000, 1'b1);
				end else if (fp_code == CODE_WORDS) begin
					for (i = 0; i < NUM_FIELDS; i++)
						emit_result(ST_FIELD, i[2:0], {captured(2 * i), captured(2 * i + 1)},
							i == NUM_FIELDS - 1);
				end else if (fp_code == CODE_MIXED) begin
					for (i = 0; i < NUM_FIELDS - 1; i++)
						emit_result(ST_FIELD, i[2:0], {8'h00, captured(i)}, 1'b0);
					emit_result(ST_FIELD, 3'd4, {captured(4), captured(5)}, 1'b1);
				end else if (fp_code == CODE_PAIR) begin
					emit_result(ST_FIELD, 3'd0, {8'h00, captured(0)}, 1'b0);
					emit_result(ST_FIELD, 3'd1, {8'h00, captured(1)}, 1'b1);
				end else begin
					emit_result(ST_NOFIELD, 3'd0, 16'h0000, 1'b1);
				end
			end
			default: fp_phase = PH_IDLE;
		endcase
	endfunction

	// Drive one byte beat; on the add-on byte of a typed row the typed result stands in.
	task automatic send_byte(input logic [7:0] b, input bit typed, input frame_result_t want);
		int gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		new_results.delete();
		parse_byte(b);
		if (typed)
			pending_results.push_back(want);
		else
			foreach (new_results[k]) pending_results.push_back(new_results[k]);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [7:0] dest, input logic [7:0] code,
			input logic [7:0] len, input fill_t fill, input logic [7:0] seed, input ck_t ck,
			input int cut, input bit typed, input frame_result_t want);
		logic [7:0] frame_bytes[$];
		logic [7:0] s, ss, b;
		int i, n;
		frame_bytes.push_back(HEADER_BYTE);
		frame_bytes.push_back(dest);
		frame_bytes.push_back(code);
		frame_bytes.push_back(len);
		// Stop at the length byte when the length is out of range.
		if (len < MAX_LEN) begin
			for (i = 0; i < len; i++) begin
				case (fill)
					FILL_CONST: b = seed;
					FILL_RAMP:  b = seed + i[7:0];
					default:    b = 8'($urandom_range(0, 255));
				endcase
				frame_bytes.push_back(b);
			end
			s = '0;
			ss = '0;
			foreach (frame_bytes[k]) begin
				s = s + frame_bytes[k];
				ss = ss + s;
			end
			if (ck == CK_BAD_SUM) s = s ^ (8'h01 << $urandom_range(0, 7));
			if (ck == CK_BAD_ADDON) ss = ss ^ (8'h01 << $urandom_range(0, 7));
			frame_bytes.push_back(s);
			frame_bytes.push_back(ss);
		end
		n = (cut > 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size();
		for (i = 0; i < n; i++)
			send_byte(frame_bytes[i], typed && i == n - 1, want);
	endtask

	task automatic random_traffic(input int budget);
		int start, pick, len, cut;
		logic [7:0] dest, code;
		ck_t ck;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			pick = $urandom_range(0, 99);
			dest = $urandom_range(0, 1) ? own_addr : bcast_addr;
			case ($urandom_range(0, 3))
				0:       code = CODE_WORDS;
				1:       code = CODE_MIXED;
				2:       code = CODE_PAIR;
				default: code = 8'($urandom_range(0, 255));
			endcase
			len = ($urandom_range(0, 39) == 0) ? $urandom_range(CAPTURE_BYTES, MAX_LEN - 1)
				: $urandom_range(0, 12);
			ck = CK_GOOD;
			if ($urandom_range(0, 9) == 0) ck = $urandom_range(0, 1) ? CK_BAD_SUM : CK_BAD_ADDON;
			cut = 0;
			if (pick < 10) begin
				send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
			end else begin
				if (pick < 14) begin
					do dest = 8'($urandom_range(0, 255));
					while (dest == own_addr || dest == bcast_addr);
				end else if (pick < 17) begin
					len = $urandom_range(MAX_LEN, 255);
				end else if (pick < 20) begin
					cut = $urandom_range(1, len + 5);
				end
				send_frame(dest, code, len[7:0], FILL_RANDOM, 8'h00, ck, cut, 1'b0, '0);
			end
		end
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_OWN_ADDR)
			own_addr = data;
		else if (idx == CFG_BCAST_ADDR)
			bcast_addr = data;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drop valid and let the expected-result queue run dry.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : receiver
		@(posedge clk);
		forever begin
			if (idle_on && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	always @(posedge clk) begin : result_check
		frame_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with none expected", frame_code, 0);
			end else begin
				want = pending_results.pop_front();
				if (status != want.status) report_mismatch("status", status, want.status);
				if (frame_code != want.code) report_mismatch("frame_code", frame_code, want.code);
				if (field_index != want.index)
					report_mismatch("field_index", field_index, want.index);
				if (field_value != want.value)
					report_mismatch("field_value", field_value, want.value);
				if (last != want.last) report_mismatch("last", last, want.last);
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		logic [7:0] shared;
		int waited;
		directed_rows = '{
			'{8'hFF, 8'h01, 8'd0, FILL_CONST, 8'h00, CK_BAD_ADDON, 1'b1,
				'{ST_CKFAIL, 8'h01, 3'd0, 16'h0000, 1'b1}},
			'{8'h00, 8'h00, 8'd0, FILL_CONST, 8'h00, CK_GOOD, 1'b1,
				'{ST_NOFIELD, 8'h00, 3'd0, 16'h0000, 1'b1}},
			'{8'hFF, 8'hFF, 8'd1, FILL_CONST, 8'hFF, CK_GOOD, 1'b1,
				'{ST_NOFIELD, 8'hFF, 3'd0, 16'h0000, 1'b1}},
			'{8'h00, CODE_WORDS, 8'd10, FILL_RAMP, 8'h01, CK_GOOD, 1'b0, '0},
			'{8'hFF, CODE_WORDS, 8'd10, FILL_CONST, 8'hFF, CK_GOOD, 1'b0, '0},
			'{8'h00, CODE_MIXED, 8'd6, FILL_RAMP, 8'hF0, CK_GOOD, 1'b0, '0},
			'{8'hFF, CODE_MIXED, 8'd3, FILL_RAMP, 8'h10, CK_GOOD, 1'b0, '0},
			'{8'h00, CODE_PAIR, 8'd0, FILL_CONST, 8'h00, CK_GOOD, 1'b0, '0},
			'{8'h00, CODE_WORDS, 8'd14, FILL_RAMP, 8'h20, CK_GOOD, 1'b0, '0},
			'{8'h55, CODE_PAIR, 8'd2, FILL_CONST, 8'hAA, CK_GOOD, 1'b0, '0},
			'{8'h00, CODE_PAIR, MAX_LEN, FILL_CONST, 8'h00, CK_GOOD, 1'b0, '0},
			'{8'hFF, CODE_PAIR, 8'hFF, FILL_CONST, 8'h00, CK_GOOD, 1'b0, '0},
			'{8'h00, CODE_MIXED, 8'd2, FILL_RAMP, 8'h7E, CK_BAD_SUM, 1'b1,
				'{ST_CKFAIL, CODE_MIXED, 3'd0, 16'h0000, 1'b1}},
			'{8'hFF, CODE_PAIR, MAX_LEN - 8'd1, FILL_RANDOM, 8'h00, CK_GOOD, 1'b0, '0}
		};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			send_frame(directed_rows[r].dest, directed_rows[r].code, directed_rows[r].len,
				directed_rows[r].fill, directed_rows[r].seed, directed_rows[r].ck, 0,
				directed_rows[r].typed, directed_rows[r].want);

		settle();
		write_reg(CFG_OWN_ADDR, 8'hFF);
		write_reg(CFG_BCAST_ADDR, 8'h00);
		write_reg(CFG_SPARE, 8'h5A);
		write_reg(CFG_TOP, 8'hA5);
		random_traffic(RANDOM_BUDGET);

		settle();
		write_reg(CFG_OWN_ADDR, 8'($urandom_range(1, 254)));
		write_reg(CFG_BCAST_ADDR, 8'($urandom_range(0, 255)));
		random_traffic(RANDOM_BUDGET);

		// Own and broadcast address the same.
		settle();
		shared = 8'($urandom_range(0, 255));
		write_reg(CFG_OWN_ADDR, shared);
		write_reg(CFG_BCAST_ADDR, shared);
		random_traffic(RANDOM_BUDGET);

		settle();
		idle_on = 1'b0;
		write_reg(CFG_OWN_ADDR, 8'h00);
		write_reg(CFG_BCAST_ADDR, 8'hFF);
		random_traffic(RANDOM_BUDGET);

		in_valid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never delivered", pending_results.size(), 0);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/scfp_pkg.sv
sv/scfp_front.sv
sv/scfp_queue.sv
sv/scfp_back.sv
sv/serial_command_frame_parser.sv
dv/tb.sv
